FILE: design/rmpd_pkg.sv
// shared types, constants and sequencer states for the range max pair difference block
package rmpd_pkg;

    // default geometry of the sample store
    localparam int DEFAULT_STORE_DEPTH  = 1024;
    localparam int DEFAULT_SAMPLE_WIDTH = 16;

    // fixed field widths
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 16;
    localparam int DIFF_W  = 18;

    // result constants
    localparam int NO_PAIR_VALUE = -99999;
    localparam int DIFF_MAX      = 131071;
    localparam int DIFF_MIN      = -131072;

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // input beat
    typedef struct packed {
        logic                      operation;
        logic [INDEX_W-1:0]        load_index;
        logic signed [VALUE_W-1:0] load_value;
        logic [INDEX_W-1:0]        range_start;
        logic [INDEX_W-1:0]        range_end;
    } t_in_item;

    // result beat
    typedef struct packed {
        logic signed [DIFF_W-1:0] max_difference;
        logic                     empty_range;
        logic                     range_error;
    } t_out_item;

    // query sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_PRIME,
        S_MIN,
        S_WALK,
        S_DONE
    } t_state;

endpackage

FILE: design/rmpd_stream_if.sv
// valid/ready stream channel carrying one payload beat
interface rmpd_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/range_max_pair_difference.sv
// top level: sample store with a sequenced max pair difference query
//
// i_item carries load and query beats; o_result carries one beat per query.
// A load beat writes one sample into the store in the cycle it is accepted
// and gives no result; an index at or beyond the depth is dropped.
// A query walks the store from range_start to range_end through one
// subtract/compare unit, one entry per cycle from the single read port,
// keeping a running minimum of earlier samples and the best difference.
// From query accept to o_result.valid, a valid non-empty range passes through
// S_PRIME, S_MIN, S_WALK and S_DONE, and an empty or out-of-range query goes
// straight to S_DONE; S_DONE waits for the output register to be free, and the
// next beat is taken once the sequencer is back in S_IDLE.
// i_item.ready is high only while the sequencer is idle, so one query is in
// work at a time; loads are taken at one per cycle while the sequencer is idle.
// The result sits in an output register: a new item is accepted while it
// waits, and a finished query holds in its last step until the receiver takes
// the previous result.
// Reset clears the sequencer and the output valid; store contents are
// undefined until loaded, and no clearing pass is run.
module range_max_pair_difference #(
    parameter int STORE_DEPTH  = rmpd_pkg::DEFAULT_STORE_DEPTH,
    parameter int SAMPLE_WIDTH = rmpd_pkg::DEFAULT_SAMPLE_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rmpd_stream_if.sink   i_item,
    rmpd_stream_if.source o_result
);

    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int IDX_W  = (ADDR_W > rmpd_pkg::INDEX_W) ? ADDR_W : rmpd_pkg::INDEX_W;
    localparam int BW     = (SAMPLE_WIDTH + 1 > rmpd_pkg::DIFF_W) ?
                            SAMPLE_WIDTH + 1 : rmpd_pkg::DIFF_W;

    localparam logic signed [BW-1:0] NO_PAIR_W = BW'(rmpd_pkg::NO_PAIR_VALUE);
    localparam logic signed [BW-1:0] SAT_HI    = BW'(rmpd_pkg::DIFF_MAX);
    localparam logic signed [BW-1:0] SAT_LO    = BW'(rmpd_pkg::DIFF_MIN);

    rmpd_pkg::t_state r_state, n_state;

    logic                           w_accept;
    logic                           w_ready;
    logic                           w_out_free;
    logic                           w_load_we;
    logic                           w_err;
    logic                           w_empty;
    logic [31:0]                    w_lv32;
    logic [SAMPLE_WIDTH-1:0]        w_store_val;
    logic [IDX_W-1:0]               w_load_idx;
    logic [IDX_W-1:0]               w_start_idx;
    logic [IDX_W-1:0]               w_end_idx;

    logic [SAMPLE_WIDTH-1:0]        r_mem [STORE_DEPTH];
    logic [SAMPLE_WIDTH-1:0]        r_rd;
    logic [ADDR_W-1:0]              r_addr;
    logic [ADDR_W-1:0]              r_rd_idx;
    logic [ADDR_W-1:0]              r_end;
    logic signed [SAMPLE_WIDTH-1:0] r_min;
    logic signed [BW-1:0]           r_best;
    logic                           r_empty;
    logic                           r_err;
    logic                           r_out_valid;
    rmpd_pkg::t_out_item            r_out;

    logic signed [BW-1:0]           w_cur;
    logic signed [BW-1:0]           w_min;
    logic signed [BW-1:0]           w_diff;
    logic signed [rmpd_pkg::DIFF_W-1:0] w_sat;

    // handshake
    assign w_accept   = i_item.valid & w_ready;
    assign w_out_free = ~r_out_valid | o_result.ready;

    // input decode and index checks
    assign w_lv32      = {16'b0, i_item.data.load_value};
    assign w_store_val = w_lv32[SAMPLE_WIDTH-1:0];
    assign w_load_idx  = IDX_W'(i_item.data.load_index);
    assign w_start_idx = IDX_W'(i_item.data.range_start);
    assign w_end_idx   = IDX_W'(i_item.data.range_end);
    assign w_err   = (32'(i_item.data.range_start) >= 32'(STORE_DEPTH)) |
                     (32'(i_item.data.range_end) >= 32'(STORE_DEPTH));
    assign w_empty = i_item.data.range_start >= i_item.data.range_end;
    assign w_load_we = w_accept & (i_item.data.operation == rmpd_pkg::OP_LOAD) &
                       (32'(i_item.data.load_index) < 32'(STORE_DEPTH));

    // sample store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_load_we) begin
            r_mem[w_load_idx[ADDR_W-1:0]] <= w_store_val;
        end
        r_rd <= r_mem[r_addr];
    end

    // shared subtract/compare unit
    assign w_cur  = {{(BW-SAMPLE_WIDTH){r_rd[SAMPLE_WIDTH-1]}}, r_rd};
    assign w_min  = {{(BW-SAMPLE_WIDTH){r_min[SAMPLE_WIDTH-1]}}, r_min};
    assign w_diff = w_cur - w_min;

    // saturate to the result width
    always_comb begin
        if (r_best > SAT_HI) begin
            w_sat = rmpd_pkg::DIFF_W'(rmpd_pkg::DIFF_MAX);
        end else if (r_best < SAT_LO) begin
            w_sat = rmpd_pkg::DIFF_W'(rmpd_pkg::DIFF_MIN);
        end else begin
            w_sat = r_best[rmpd_pkg::DIFF_W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rmpd_pkg::S_IDLE: begin
                if (w_accept && i_item.data.operation == rmpd_pkg::OP_QUERY) begin
                    n_state = (w_err | w_empty) ? rmpd_pkg::S_DONE : rmpd_pkg::S_PRIME;
                end
            end
            rmpd_pkg::S_PRIME: n_state = rmpd_pkg::S_MIN;
            rmpd_pkg::S_MIN:   n_state = rmpd_pkg::S_WALK;
            rmpd_pkg::S_WALK: begin
                if (r_rd_idx == r_end) begin
                    n_state = rmpd_pkg::S_DONE;
                end
            end
            rmpd_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = rmpd_pkg::S_IDLE;
                end
            end
            default: n_state = rmpd_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        case (r_state)
            rmpd_pkg::S_IDLE: w_ready = 1'b1;
            default:          w_ready = 1'b0;
        endcase
    end

    assign i_item.ready   = w_ready;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rmpd_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == rmpd_pkg::S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // walk datapath
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        case (r_state)
            rmpd_pkg::S_IDLE: begin
                if (w_accept) begin
                    r_addr  <= w_start_idx[ADDR_W-1:0];
                    r_end   <= w_end_idx[ADDR_W-1:0];
                    r_best  <= NO_PAIR_W;
                    r_empty <= w_empty;
                    r_err   <= w_err;
                end
            end
            rmpd_pkg::S_PRIME: begin
                if (r_addr != r_end) begin
                    r_addr <= r_addr + 1'b1;
                end
            end
            rmpd_pkg::S_MIN: begin
                r_min <= r_rd;
                if (r_addr != r_end) begin
                    r_addr <= r_addr + 1'b1;
                end
            end
            rmpd_pkg::S_WALK: begin
                if (w_diff > r_best) begin
                    r_best <= w_diff;
                end
                if (w_cur < w_min) begin
                    r_min <= r_rd;
                end
                if (r_addr != r_end) begin
                    r_addr <= r_addr + 1'b1;
                end
            end
            rmpd_pkg::S_DONE: begin
                if (w_out_free) begin
                    r_out.max_difference <= w_sat;
                    r_out.empty_range    <= r_empty;
                    r_out.range_error    <= r_err;
                end
            end
            default: begin
                r_addr <= r_addr;
            end
        endcase
    end

endmodule

FILE: bench/range_max_pair_difference_tb.sv
`timescale 1ns / 1ps
// self-checking bench for range_max_pair_difference: directed rows, then random loads and queries
module range_max_pair_difference_tb;

    localparam int     STORE_DEPTH  = rmpd_pkg::DEFAULT_STORE_DEPTH;
    localparam int     SAMPLE_WIDTH = rmpd_pkg::DEFAULT_SAMPLE_WIDTH;
    localparam int     INDEX_W      = rmpd_pkg::INDEX_W;
    localparam int     VALUE_W      = rmpd_pkg::VALUE_W;
    localparam int     DIFF_W       = rmpd_pkg::DIFF_W;
    localparam int     IN_W         = $bits(rmpd_pkg::t_in_item);
    localparam int     RANDOM_ITEMS = 560;
    localparam int     TAIL_CYCLES  = STORE_DEPTH + 16;
    localparam int     MAX_REPORTS  = 10;
    localparam int     SHORT_RANGE  = 12;
    localparam longint RUN_LIMIT_NS = 10_000_000;

    // one directed stimulus row, with an optional hand-written result
    typedef struct {
        rmpd_pkg::t_in_item  beat;
        bit                  typed;
        rmpd_pkg::t_out_item result;
    } t_directed_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    rmpd_stream_if #(.T(rmpd_pkg::t_in_item))  item_if ();
    rmpd_stream_if #(.T(rmpd_pkg::t_out_item)) result_if ();

    range_max_pair_difference #(
        .STORE_DEPTH (STORE_DEPTH),
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_result(result_if)
    );

    // mirror of the sample store and which entries hold a loaded value
    longint              sample_mirror [STORE_DEPTH];
    bit                  written       [STORE_DEPTH];
    rmpd_pkg::t_out_item awaited_results [$];
    t_directed_row       directed_rows   [$];

    int fault_count   = 0;
    int items_sent    = 0;
    int total_items   = 1;
    int src_idle_pct  = 28;
    int sink_idle_pct = 56;
    int fill_ptr      = 6;

    always #1 i_clk = ~i_clk;

    // receiver: random back-pressure, one decision per cycle
    always @(negedge i_clk) begin
        result_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // compare every result beat with the oldest awaited result
    always @(posedge i_clk) begin
        rmpd_pkg::t_out_item want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (awaited_results.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("unawaited result beat: max_difference %0d empty %0b error %0b",
                             $signed(result_if.data.max_difference),
                             result_if.data.empty_range, result_if.data.range_error);
            end else begin
                want = awaited_results.pop_front();
                if (result_if.data.max_difference !== want.max_difference ||
                    result_if.data.empty_range !== want.empty_range ||
                    result_if.data.range_error !== want.range_error) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display("mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
                                 $signed(want.max_difference),
                                 want.empty_range, want.range_error,
                                 $signed(result_if.data.max_difference),
                                 result_if.data.empty_range, result_if.data.range_error);
                end
            end
        end
    end

    // best later-minus-earlier difference over the range, one walk with a running minimum
    function automatic rmpd_pkg::t_out_item max_pair_difference(input rmpd_pkg::t_in_item beat);
        rmpd_pkg::t_out_item res;
        longint              best;
        longint              run_min;
        longint              diff;
        int                  j;
        best            = rmpd_pkg::NO_PAIR_VALUE;
        res.empty_range = (beat.range_start >= beat.range_end);
        res.range_error = (beat.range_start >= STORE_DEPTH) || (beat.range_end >= STORE_DEPTH);
        if (!res.empty_range && !res.range_error) begin
            run_min = sample_mirror[beat.range_start];
            for (j = beat.range_start + 1; j <= beat.range_end; j++) begin
                diff = sample_mirror[j] - run_min;
                if (diff > best)
                    best = diff;
                if (sample_mirror[j] < run_min)
                    run_min = sample_mirror[j];
            end
        end
        if (best > rmpd_pkg::DIFF_MAX)
            best = rmpd_pkg::DIFF_MAX;
        if (best < rmpd_pkg::DIFF_MIN)
            best = rmpd_pkg::DIFF_MIN;
        res.max_difference = best[DIFF_W-1:0];
        return res;
    endfunction

    // drive one item beat, wait for acceptance, then update the mirror or await a result
    task automatic send_beat(input rmpd_pkg::t_in_item beat, input bit typed,
                             input rmpd_pkg::t_out_item typed_result);
        longint value;
        if (items_sent < total_items / 3) begin
            src_idle_pct  = 28;
            sink_idle_pct = 56;
        end else if (items_sent < 2 * total_items / 3) begin
            src_idle_pct  = 56;
            sink_idle_pct = 28;
        end else begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < src_idle_pct) begin
            item_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.data  <= beat;
        do @(posedge i_clk); while (!item_if.ready);
        items_sent++;
        if (beat.operation == rmpd_pkg::OP_LOAD) begin
            if (beat.load_index < STORE_DEPTH) begin
                // field taken as raw bits, then low sample bits kept with the top kept bit as sign
                value = longint'({48'b0, beat.load_value});
                value = (value <<< (64 - SAMPLE_WIDTH)) >>> (64 - SAMPLE_WIDTH);
                sample_mirror[beat.load_index] = value;
                written[beat.load_index]       = 1'b1;
            end
        end else begin
            awaited_results.push_back(typed ? typed_result : max_pair_difference(beat));
        end
        @(negedge i_clk);
    endtask

    // directed rows: unused fields carry random noise
    task automatic add_load(input int idx, input int value);
        t_directed_row row;
        row.beat            = IN_W'({$urandom, $urandom});
        row.beat.operation  = rmpd_pkg::OP_LOAD;
        row.beat.load_index = INDEX_W'(idx);
        row.beat.load_value = VALUE_W'(value);
        row.typed           = 1'b0;
        row.result          = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_query(input int rs, input int re, input bit typed, input int diff,
                             input bit empty);
        t_directed_row row;
        row.beat                  = IN_W'({$urandom, $urandom});
        row.beat.operation        = rmpd_pkg::OP_QUERY;
        row.beat.range_start      = INDEX_W'(rs);
        row.beat.range_end        = INDEX_W'(re);
        row.typed                 = typed;
        row.result.max_difference = DIFF_W'(diff);
        row.result.empty_range    = empty;
        row.result.range_error    = 1'b0;
        directed_rows.push_back(row);
    endtask

    // random part: loads that grow written runs or land at random indices, queries over written runs, empty queries
    task automatic run_random_items();
        rmpd_pkg::t_in_item beat;
        int                 pick;
        int                 s;
        int                 e;
        int                 len;
        int                 i;
        int                 step;
        bit                 found;
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            beat = IN_W'({$urandom, $urandom});
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                beat.operation = rmpd_pkg::OP_LOAD;
                if ($urandom_range(0, 99) < 3)
                    fill_ptr = $urandom_range(0, STORE_DEPTH - 1);
                if ($urandom_range(0, 1)) begin
                    beat.load_index = INDEX_W'(fill_ptr);
                    fill_ptr        = (fill_ptr + 1) % STORE_DEPTH;
                end
                case ($urandom_range(0, 7))
                    0: beat.load_value = 16'sh8000;
                    1: beat.load_value = 16'sh7fff;
                    default: ;
                endcase
            end else begin
                beat.operation = rmpd_pkg::OP_QUERY;
                found          = 1'b0;
                if (pick >= 58) begin
                    // look for a written start with a written entry right after it
                    s = $urandom_range(0, STORE_DEPTH - 2);
                    for (step = 0; step < STORE_DEPTH - 1 && !found; step++) begin
                        if (written[s] && written[s + 1])
                            found = 1'b1;
                        else
                            s = (s + 1) % (STORE_DEPTH - 1);
                    end
                end
                if (found) begin
                    e = s + 1;
                    while (e + 1 < STORE_DEPTH && written[e + 1])
                        e++;
                    if ($urandom_range(0, 99) < 85)
                        len = $urandom_range(1, (e - s < SHORT_RANGE) ? e - s : SHORT_RANGE);
                    else
                        len = $urandom_range(1, e - s);
                    beat.range_start = INDEX_W'(s);
                    beat.range_end   = INDEX_W'(s + len);
                end else begin
                    s                = $urandom_range(0, STORE_DEPTH - 1);
                    beat.range_start = INDEX_W'(s);
                    beat.range_end   = INDEX_W'($urandom_range(0, s));
                end
            end
            send_beat(beat, 1'b0, '0);
        end
    endtask

    // main sequence
    initial begin
        item_if.valid   = 1'b0;
        item_if.data    = '0;

        // extremes of the sample range
        add_load(0, -32768);
        add_load(1, 32767);
        add_query(0, 1, 1'b1, 65535, 1'b0);
        add_load(2, -32768);
        add_query(1, 2, 1'b1, -65535, 1'b0);
        add_query(0, 2, 1'b0, 0, 1'b0);
        // empty ranges, start equal to or above end
        add_query(2, 2, 1'b1, rmpd_pkg::NO_PAIR_VALUE, 1'b1);
        add_query(1023, 0, 1'b1, rmpd_pkg::NO_PAIR_VALUE, 1'b1);
        add_query(1023, 1023, 1'b1, rmpd_pkg::NO_PAIR_VALUE, 1'b1);
        // top of the store, equal samples and a negative best
        add_load(1023, 0);
        add_load(1022, 5);
        add_load(1021, 5);
        add_query(1021, 1023, 1'b1, 0, 1'b0);
        add_query(1022, 1023, 1'b1, -5, 1'b0);
        // running minimum moves mid-range
        add_load(3, 100);
        add_load(4, -7);
        add_load(5, 200);
        add_query(0, 5, 1'b0, 0, 1'b0);
        add_query(3, 5, 1'b0, 0, 1'b0);
        // middle of the store, then overwrite and query right after
        add_load(512, 1);
        add_load(513, -1);
        add_query(512, 513, 1'b1, -2, 1'b0);
        add_query(5, 3, 1'b1, rmpd_pkg::NO_PAIR_VALUE, 1'b1);
        add_load(513, 300);
        add_query(512, 513, 1'b1, 299, 1'b0);

        total_items = directed_rows.size() + RANDOM_ITEMS;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n])
            send_beat(directed_rows[n].beat, directed_rows[n].typed, directed_rows[n].result);
        run_random_items();
        item_if.valid <= 1'b0;

        // drain, then watch for stray beats
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fault_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #(RUN_LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule
